>>> src/ibt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibt_pkg: shared types and constants for the interval booking table
// Holds the default sizes, the result status codes, the controller states
// and the scan result bundle passed from the slot store to the controller.
// ----------------------------------------------------------------------------
package ibt_pkg;

  // default sizes
  localparam int CAPACITY_DEF  = 1024;
  localparam int TIME_BITS_DEF = 31;

  // result status codes
  typedef enum logic [1:0] {
    ST_BOOKED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // one compared slot, returned in the cycle after its read
  typedef struct packed {
    logic valid;    // a slot was compared this cycle
    logic last;     // it was the last stored slot
    logic overlap;  // it overlaps the pending request
  } hit_t;

endpackage

`default_nettype wire

>>> src/ibt_slot_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibt_slot_store: interval memory with overlap compare
// One synchronous memory holds start and end of every stored interval. A
// read returns registered data in the next cycle, where it is compared
// against the pending request for a half-open overlap.
// ----------------------------------------------------------------------------
module ibt_slot_store
  import ibt_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  input  wire logic                 rd_last,
  input  wire logic [TIME_BITS-1:0] req_start,
  input  wire logic [TIME_BITS-1:0] req_end,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [TIME_BITS-1:0] wr_start,
  input  wire logic [TIME_BITS-1:0] wr_end,
  output hit_t                      hit
);

  // slot memory: end in the upper half, start in the lower half
  logic [2*TIME_BITS-1:0] mem [CAPACITY];
  logic [2*TIME_BITS-1:0] rd_data;
  logic                   rd_valid;
  logic                   rd_last_q;
  logic [TIME_BITS-1:0]   slot_start;
  logic [TIME_BITS-1:0]   slot_end;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_end, wr_start};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // read tag pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      rd_valid  <= rd_en;
      rd_last_q <= rd_last;
    end
  end

  // half-open overlap: stored start below new end, stored end above new start
  always_comb begin
    slot_start  = rd_data[TIME_BITS-1:0];
    slot_end    = rd_data[2*TIME_BITS-1:TIME_BITS];
    hit.valid   = rd_valid;
    hit.last    = rd_last_q;
    hit.overlap = rd_valid && (slot_start < req_end) && (slot_end > req_start);
  end

endmodule

`default_nettype wire

>>> src/interval_booking_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// interval_booking_table_unit: reservation table of non-overlapping intervals
// Accepts booking requests for half-open intervals and answers each with
// booked/status, storing accepted intervals in the lowest free slot.
// ----------------------------------------------------------------------------
// Each request [start, end) is checked against the stored intervals up to
// the first overlap and answered with one result: booked, overlap, table
// full, or empty/reversed interval. Slots are never released, so the stored
// intervals always fill slots 0 to N-1 and a fill count stands in for
// per-slot valid bits; no clearing pass is needed after reset. The stored
// intervals are scanned through the single memory read port, which
// compares one stored interval per cycle. Empty or reversed intervals and
// requests made with an empty table skip the scan and go straight to the
// result. One request is worked on at a time; a new request is taken while
// the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module interval_booking_table_unit
  import ibt_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // s_tdata: start_time, end_time, zero fill
  input  wire logic [((2*TIME_BITS+7)/8)*8-1:0]  s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // m_tdata: booked, status[1:0], zero fill
  output logic [7:0]                             m_tdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  state_t               state;
  state_t               state_next;
  logic [TIME_BITS-1:0] in_start;
  logic [TIME_BITS-1:0] in_end;
  logic [TIME_BITS-1:0] req_start;
  logic [TIME_BITS-1:0] req_end;
  status_t              res;
  logic [CW-1:0]        count;
  logic [CW-1:0]        rd_idx;
  logic                 rd_en;
  logic                 rd_last;
  logic                 commit;
  logic                 wr_en;
  logic                 out_booked;
  status_t              out_status;
  hit_t                 hit;

  assign in_start = s_tdata[TIME_BITS-1:0];
  assign in_end   = s_tdata[2*TIME_BITS-1:TIME_BITS];
  assign rd_last  = (rd_idx == count - CW'(1));
  assign wr_en    = commit && (res == ST_BOOKED);
  assign m_tdata  = {5'b0, out_status, out_booked};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    commit     = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if ((in_start >= in_end) || (count == '0)) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en = (rd_idx < count);
        if (hit.valid && (hit.overlap || hit.last)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // request capture, scan index and verdict
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      req_start <= in_start;
      req_end   <= in_end;
      rd_idx    <= '0;
      if (in_start >= in_end) begin
        res <= ST_EMPTY;
      end else if (count == CAP_CNT) begin
        res <= ST_FULL;
      end else begin
        res <= ST_BOOKED;
      end
    end else if (state == S_SCAN) begin
      if (rd_en) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (hit.valid && hit.overlap) begin
        res <= ST_OVERLAP;
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_booked <= (res == ST_BOOKED);
      out_status <= res;
    end
  end

  // interval memory and compare
  ibt_slot_store #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS),
    .AW        (AW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_addr   (rd_idx[AW-1:0]),
    .rd_last   (rd_last),
    .req_start (req_start),
    .req_end   (req_end),
    .wr_en     (wr_en),
    .wr_addr   (count[AW-1:0]),
    .wr_start  (req_start),
    .wr_end    (req_end),
    .hit       (hit)
  );

endmodule

`default_nettype wire

>>> verif/interval_booking_table_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// interval_booking_table_unit_tb: self-checking bench for the booking table
// Sends booking requests over the stream input and keeps its own copy of the
// slot table to predict booked/status for each one. A short directed table
// covers empty and reversed intervals, touching and overlapping intervals and
// the time extremes. Random requests follow, the last stretch without idling.
// Each reply is compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module interval_booking_table_unit_tb;
  import ibt_pkg::*;

  localparam int            TW              = TIME_BITS_DEF;
  localparam int            SLOTS           = CAPACITY_DEF;
  localparam int            IN_W            = ((2*TW+7)/8)*8;
  localparam logic [TW-1:0] T_MAX           = '1;
  localparam int            RANDOM_REQUESTS = 560;
  localparam int            CALM_TAIL       = 60;
  localparam int            LONG_HOLD       = 300;
  localparam int            TAIL_CYCLES     = SLOTS + 8;
  // fresh random intervals start at or above this
  localparam int            FRESH_LO        = 1 << 21;

  typedef struct {
    logic    booked;
    status_t status;
  } reply_t;

  typedef struct packed {
    logic [TW-1:0] lo;
    logic [TW-1:0] hi;
    logic          typed;   // expected reply written in the row
    logic          booked;
    status_t       status;
  } dir_row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata;
  logic            m_tvalid;
  logic            m_tready;
  logic [7:0]      m_tdata;

  // local copy of the slot table
  logic [TW-1:0] slot_lo [SLOTS];
  logic [TW-1:0] slot_hi [SLOTS];
  bit            slot_taken [SLOTS];
  int            n_booked = 0;

  reply_t expected_replies [$];
  int     fail_count = 0;
  bit     idle_on = 1'b1;
  bit     hold_long = 1'b0;

  // directed requests, starting from an empty table
  dir_row_t directed_rows [19] = '{
    '{31'd0,            31'd0,            1'b1, 1'b0, ST_EMPTY},
    '{T_MAX,            T_MAX,            1'b1, 1'b0, ST_EMPTY},
    '{T_MAX,            31'd0,            1'b1, 1'b0, ST_EMPTY},
    '{31'd5,            31'd4,            1'b1, 1'b0, ST_EMPTY},
    '{31'd0,            31'd1,            1'b1, 1'b1, ST_BOOKED},
    '{31'd0,            31'd1,            1'b1, 1'b0, ST_OVERLAP},
    '{31'd1,            31'd2,            1'b0, 1'b0, ST_BOOKED},
    '{T_MAX - 31'd1,    T_MAX,            1'b0, 1'b0, ST_BOOKED},
    '{31'd0,            T_MAX,            1'b1, 1'b0, ST_OVERLAP},
    '{31'd2,            31'd3,            1'b0, 1'b0, ST_BOOKED},
    '{31'd1,            31'd3,            1'b0, 1'b0, ST_BOOKED},
    '{T_MAX - 31'd2,    T_MAX - 31'd1,    1'b0, 1'b0, ST_BOOKED},
    '{31'd3,            31'd1000,         1'b0, 1'b0, ST_BOOKED},
    '{31'd500,          31'd600,          1'b0, 1'b0, ST_BOOKED},
    '{31'd999,          31'd2000,         1'b0, 1'b0, ST_BOOKED},
    '{31'h2AAA_AAAA,    31'h2AAA_AAAB,    1'b0, 1'b0, ST_BOOKED},
    '{31'h5555_5554,    31'h5555_5555,    1'b0, 1'b0, ST_BOOKED},
    '{31'd2000,         31'd1000,         1'b1, 1'b0, ST_EMPTY},
    '{T_MAX - 31'd1,    T_MAX,            1'b1, 1'b0, ST_OVERLAP}
  };

  interval_booking_table_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // start_time, end_time, zero fill
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)     // booked, status[1:0], zero fill
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predict one request and update the local table; lowest free slot wins
  function automatic status_t reserve_interval(input logic [TW-1:0] st,
                                               input logic [TW-1:0] en);
    int free_slot;
    free_slot = -1;
    if (st >= en) return ST_EMPTY;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_taken[i]) begin
        if (slot_lo[i] < en && slot_hi[i] > st) return ST_OVERLAP;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (free_slot < 0) return ST_FULL;
    slot_lo[free_slot]    = st;
    slot_hi[free_slot]    = en;
    slot_taken[free_slot] = 1'b1;
    n_booked++;
    return ST_BOOKED;
  endfunction

  // offer one request; entered and left at a falling edge
  task automatic send_request(input logic [TW-1:0] st, input logic [TW-1:0] en,
                              input logic typed, input reply_t typed_reply);
    reply_t  want;
    status_t code;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W-2*TW){1'b0}}, en, st};
    do @(posedge clk); while (!s_tready);
    code        = reserve_interval(st, en);
    want.booked = (code == ST_BOOKED);
    want.status = code;
    expected_replies.push_back(typed ? typed_reply : want);
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding reply
  task automatic wait_replies();
    s_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(negedge clk);
  endtask

  // random request: mostly fresh short intervals and intervals built around
  // a stored one (touching, identical, inside, straddling), plus reversed
  // and wide ones
  task automatic pick_random(output logic [TW-1:0] st, output logic [TW-1:0] en);
    longint lo, hi, len, base_lo, base_hi;
    int     k, pick;
    pick = $urandom_range(0, 99);
    len  = ($urandom_range(0, 1) == 0) ? longint'($urandom_range(1, 16))
                                       : longint'($urandom_range(1, 65536));
    if (pick < 50 || n_booked == 0) begin
      lo = $urandom_range(T_MAX - 1, FRESH_LO);
      hi = lo + len;
    end else if (pick < 75) begin
      k       = $urandom_range(0, n_booked - 1);
      base_lo = slot_lo[k];
      base_hi = slot_hi[k];
      case ($urandom_range(0, 5))
        0: begin
          hi = base_lo;
          lo = base_lo - len;
        end
        1: begin
          lo = base_hi;
          hi = base_hi + len;
        end
        2: begin
          lo = base_lo;
          hi = base_hi;
        end
        3: begin
          lo = base_lo + longint'($urandom_range(0, base_hi - base_lo - 1));
          hi = lo + longint'($urandom_range(1, base_hi - lo));
        end
        4: begin
          lo = base_lo - len;
          hi = base_lo + 1;
        end
        default: begin
          lo = base_hi - 1;
          hi = base_hi + len;
        end
      endcase
    end else if (pick < 85) begin
      lo = $urandom_range(T_MAX, 0);
      hi = $urandom_range(lo, 0);
    end else begin
      lo = $urandom_range(T_MAX - 1, FRESH_LO);
      hi = $urandom_range(T_MAX, lo + 1);
    end
    if (lo < 0) lo = 0;
    if (hi > longint'(T_MAX)) hi = T_MAX;
    st = lo[TW-1:0];
    en = hi[TW-1:0];
  endtask

  // stimulus
  initial begin : stimulus
    logic [TW-1:0] st, en;
    reply_t        typed_reply;
    s_tvalid           = 1'b0;
    s_tdata            = '0;
    typed_reply.booked = 1'b0;
    typed_reply.status = ST_BOOKED;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[r]) begin
      typed_reply.booked = directed_rows[r].booked;
      typed_reply.status = directed_rows[r].status;
      send_request(directed_rows[r].lo, directed_rows[r].hi,
                   directed_rows[r].typed, typed_reply);
    end
    wait_replies();

    // random requests; the receiver stalls long right at the start and the
    // last stretch runs with no idling
    hold_long = 1'b1;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      idle_on = (n < RANDOM_REQUESTS - CALM_TAIL) && (((n / 40) % 3) != 2);
      pick_random(st, en);
      send_request(st, en, 1'b0, typed_reply);
    end
    wait_replies();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("interval_booking_table_unit_tb passed");
    end else begin
      $display("interval_booking_table_unit_tb failed");
    end
    $finish;
  end

  // output ready: long hold on request, random stall bursts, ready stretches
  initial begin : reply_sink
    int stall;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        m_tready <= 1'b0;
        stall = LONG_HOLD;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        stall = $urandom_range(1, 13);
      end else begin
        m_tready <= 1'b1;
        stall = $urandom_range(1, 24);
      end
      repeat (stall) @(negedge clk);
    end
  end

  // compare each reply with the oldest prediction
  always @(posedge clk) begin : reply_check
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_replies.size() == 0) begin
        $error("reply with none outstanding: booked=%0d status=%0d",
               m_tdata[0], m_tdata[2:1]);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        if (m_tdata[0] !== want.booked) begin
          $error("booked: expected %0d, got %0d", want.booked, m_tdata[0]);
          fail_count++;
        end
        if (m_tdata[2:1] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[2:1]);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    #12_000_000;
    $display("interval_booking_table_unit_tb failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
src/ibt_pkg.sv
src/ibt_slot_store.sv
src/interval_booking_table_unit.sv
verif/interval_booking_table_unit_tb.sv
